// ----- src/logg_pkg.sv -----
// Package: shared types, constants and helpers for the log-odds occupancy grid.
package logg_pkg;

   localparam int SIZE_X_DEF = 64;
   localparam int SIZE_Y_DEF = 64;
   localparam int SIZE_Z_DEF = 4;

   localparam int CELL_W  = 16;
   localparam int COORD_W = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [15:0] MISS_STEP_RST     = -16'sd415;
   localparam logic        [14:0] HIT_STEP_RST      = 15'd868;
   localparam logic signed [15:0] CLAMP_LOW_RST     = -16'sd2040;
   localparam logic signed [15:0] CLAMP_HIGH_RST    = 16'sd3560;
   localparam logic signed [15:0] OCC_THRESHOLD_RST = 16'sd0;

   localparam logic signed [15:0] CELL_MAX = 16'sh7FFF;
   localparam logic signed [15:0] CELL_MIN = 16'sh8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MISS_STEP     = 3'd0,
      CSR_HIT_STEP      = 3'd1,
      CSR_CLAMP_LOW     = 3'd2,
      CSR_CLAMP_HIGH    = 3'd3,
      CSR_OCC_THRESHOLD = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      REQ_FREE     = 2'd0,
      REQ_OCCUPIED = 2'd1,
      REQ_UNKNOWN  = 2'd2,
      REQ_QUERY    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CLASS_UNKNOWN  = 2'd0,
      CLASS_FREE     = 2'd1,
      CLASS_OCCUPIED = 2'd2
   } cell_class_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic [1:0]         cell_z;
   } req_word_type;

   typedef struct packed {
      logic                     class_changed;
      logic [1:0]               cell_class;
      logic signed [CELL_W-1:0] log_odds;
   } rsp_word_type;

   typedef struct packed {
      logic signed [15:0] miss_step;
      logic        [14:0] hit_step;
      logic signed [15:0] clamp_low;
      logic signed [15:0] clamp_high;
      logic signed [15:0] occ_threshold;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_en;
      logic load;
      logic exec;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
   } dp_status_type;

   typedef logic [63:0][COORD_W-1:0] mod_tab_type;

   // coordinate reduction table, built by counting so no divider is involved
   function automatic mod_tab_type mod_table(input int unsigned size);
      mod_tab_type        tab;
      logic [COORD_W-1:0] cnt;
      cnt = '0;
      for (int i = 0; i < 64; i++) begin
         tab[i] = cnt;
         if (int'(cnt) + 1 >= int'(size)) begin
            cnt = '0;
         end else begin
            cnt = cnt + 1'b1;
         end
      end
      return tab;
   endfunction

   function automatic logic [1:0] class_of(input logic signed [15:0] v,
                                           input logic signed [15:0] thr);
      logic [1:0] c;
      if (v < thr) begin
         c = CLASS_FREE;
      end else if (v > thr) begin
         c = CLASS_OCCUPIED;
      end else begin
         c = CLASS_UNKNOWN;
      end
      return c;
   endfunction

endpackage

// ----- src/logg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module logg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/logg_csr.sv -----
// Configuration registers: step sizes, clamp limits and class threshold.
module logg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [logg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                        csr_wdata,
   output logg_pkg::cfg_type                  cfg
);

   logg_pkg::cfg_type cfg_ff;
   logg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            logg_pkg::CSR_MISS_STEP:     cfg_in.miss_step     = csr_wdata;
            logg_pkg::CSR_HIT_STEP:      cfg_in.hit_step      = csr_wdata[14:0];
            logg_pkg::CSR_CLAMP_LOW:     cfg_in.clamp_low     = csr_wdata;
            logg_pkg::CSR_CLAMP_HIGH:    cfg_in.clamp_high    = csr_wdata;
            logg_pkg::CSR_OCC_THRESHOLD: cfg_in.occ_threshold = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.miss_step     <= logg_pkg::MISS_STEP_RST;
         cfg_ff.hit_step      <= logg_pkg::HIT_STEP_RST;
         cfg_ff.clamp_low     <= logg_pkg::CLAMP_LOW_RST;
         cfg_ff.clamp_high    <= logg_pkg::CLAMP_HIGH_RST;
         cfg_ff.occ_threshold <= logg_pkg::OCC_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/logg_ctrl.sv -----
// Controller: clearing pass after reset, then accept / execute sequencing.
module logg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logg_pkg::dp_status_type  status,
   output logg_pkg::dp_cmd_type     cmd,
   output logic                     busy
);

   logg_pkg::state_type state_ff;
   logg_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         logg_pkg::ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = logg_pkg::ST_IDLE;
            end
         end
         logg_pkg::ST_IDLE: begin
            if (start) begin
               state_in = logg_pkg::ST_EXEC;
            end
         end
         logg_pkg::ST_EXEC: begin
            state_in = logg_pkg::ST_IDLE;
         end
         default: begin
            state_in = logg_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         logg_pkg::ST_CLEAR: begin
            cmd.clr_en = 1'b1;
         end
         logg_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         logg_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= logg_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/logg_dp.sv -----
// Datapath: address forming, cell store, log-odds update and result register.
module logg_dp #(
   parameter int SIZE_X = logg_pkg::SIZE_X_DEF,
   parameter int SIZE_Y = logg_pkg::SIZE_Y_DEF,
   parameter int SIZE_Z = logg_pkg::SIZE_Z_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logg_pkg::dp_cmd_type     cmd,
   output logg_pkg::dp_status_type  status,
   input  logg_pkg::cfg_type        cfg,
   input  logg_pkg::req_word_type   req_data,
   output logic                     rsp_valid,
   output logg_pkg::rsp_word_type   rsp_data
);

   localparam int CELL_COUNT = SIZE_X * SIZE_Y * SIZE_Z;
   localparam int AW = CELL_COUNT > 1 ? $clog2(CELL_COUNT) : 1;
   localparam logg_pkg::mod_tab_type XMOD = logg_pkg::mod_table(SIZE_X);
   localparam logg_pkg::mod_tab_type YMOD = logg_pkg::mod_table(SIZE_Y);
   localparam logg_pkg::mod_tab_type ZMOD = logg_pkg::mod_table(SIZE_Z);
   localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] addr_ff;
   logic [1:0]    kind_ff;
   logg_pkg::rsp_word_type rsp_ff, rsp_in;
   logic          rsp_valid_ff;

   logic [logg_pkg::COORD_W-1:0] x_m, y_m, z_m;
   logic [AW-1:0] row, rd_addr;
   logic [15:0]   rd_data;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [15:0]   ram_wdata;

   logic signed [15:0] old, nv;
   logic signed [16:0] miss_sum, hit_sum;
   logic signed [15:0] miss_sat, hit_sat;
   logic               changed;

   // cell address = (z * SIZE_Y + y) * SIZE_X + x, coordinates wrapped first
   always_comb begin
      x_m = XMOD[req_data.cell_x];
      y_m = YMOD[req_data.cell_y];
      z_m = ZMOD[{4'd0, req_data.cell_z}];
      row = AW'(z_m) * AW'(SIZE_Y) + AW'(y_m);
      rd_addr = row * AW'(SIZE_X) + AW'(x_m);
   end

   assign clr_addr_in   = clr_addr_ff + 1'b1;
   assign status.clr_last = (clr_addr_ff == LAST_ADDR);

   always_comb begin
      old      = rd_data;
      miss_sum = {old[15], old} + {cfg.miss_step[15], cfg.miss_step};
      hit_sum  = {old[15], old} + {2'b00, cfg.hit_step};

      if (miss_sum[16] != miss_sum[15]) begin
         miss_sat = miss_sum[16] ? logg_pkg::CELL_MIN : logg_pkg::CELL_MAX;
      end else begin
         miss_sat = miss_sum[15:0];
      end
      if (hit_sum[16] != hit_sum[15]) begin
         hit_sat = hit_sum[16] ? logg_pkg::CELL_MIN : logg_pkg::CELL_MAX;
      end else begin
         hit_sat = hit_sum[15:0];
      end

      nv      = old;
      changed = 1'b0;
      case (kind_ff)
         logg_pkg::REQ_FREE: begin
            nv = (miss_sat < cfg.clamp_low) ? cfg.clamp_low : miss_sat;
            changed = !(old < cfg.occ_threshold) && (nv < cfg.occ_threshold);
         end
         logg_pkg::REQ_OCCUPIED: begin
            nv = (hit_sat > cfg.clamp_high) ? cfg.clamp_high : hit_sat;
            changed = !(old > cfg.occ_threshold) && (nv > cfg.occ_threshold);
         end
         logg_pkg::REQ_UNKNOWN: begin
            nv      = cfg.occ_threshold;
            changed = (old != cfg.occ_threshold);
         end
         default: ;
      endcase

      rsp_in.class_changed = changed;
      rsp_in.cell_class    = logg_pkg::class_of(nv, cfg.occ_threshold);
      rsp_in.log_odds      = nv;
   end

   always_comb begin
      ram_we    = cmd.clr_en | cmd.exec;
      ram_waddr = cmd.clr_en ? clr_addr_ff : addr_ff;
      ram_wdata = cmd.clr_en ? 16'd0 : nv;
   end

   logg_ram #(
      .WIDTH(logg_pkg::CELL_W),
      .DEPTH(CELL_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_en) begin
            clr_addr_ff <= clr_addr_in;
         end
         rsp_valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= rd_addr;
         kind_ff <= req_data.req_type;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/log_odds_occupancy_grid.sv -----
// Log-odds occupancy grid, top level.
// Each word is accepted when start is high and busy is low. The registered read of the cell
// store comes first; then the value is updated, written back and the result registered.
// The result shows on rsp_valid/rsp_data for one cycle, after the read register and the
// result register, and cannot be held off; busy drops again while it is shown, so a new
// word can be accepted only once the last one's result is shown. After reset the block
// clears the cell store one cell per cycle with busy high (SIZE_X*SIZE_Y*SIZE_Z cells,
// 16384 at the default sizes); configuration writes are taken at any time, but only while
// idle do they have a defined effect on a word in flight.
module log_odds_occupancy_grid #(
   parameter int SIZE_X = logg_pkg::SIZE_X_DEF,
   parameter int SIZE_Y = logg_pkg::SIZE_Y_DEF,
   parameter int SIZE_Z = logg_pkg::SIZE_Z_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logg_pkg::req_word_type         req_data,
   output logic                           rsp_valid,
   output logg_pkg::rsp_word_type         rsp_data,
   input  logic                           csr_we,
   input  logic [logg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_wdata
);

   logg_pkg::cfg_type       cfg;
   logg_pkg::dp_cmd_type    cmd;
   logg_pkg::dp_status_type status;

   logg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   logg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .status(status),
      .cmd   (cmd),
      .busy  (busy)
   );

   logg_dp #(
      .SIZE_X(SIZE_X),
      .SIZE_Y(SIZE_Y),
      .SIZE_Z(SIZE_Z)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

// ----- src/logg_checker.sv -----
// Port-level checker for the log-odds occupancy grid, bound to the top level.
module logg_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logg_pkg::req_word_type req_data,
   input logic                   rsp_valid,
   input logg_pkg::rsp_word_type rsp_data
);

   logic accept;
   assign accept = start && !busy;

   // every accepted word yields a result strobe
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("result strobe missing two cycles after accept");

   // no result strobe without an accepted word before it
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("result strobe without an accepted word");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy low right after accept");

   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // a query never reports a class change
   a_query_no_change: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.req_type == logg_pkg::REQ_QUERY)
         |-> ##2 (rsp_valid && !rsp_data.class_changed))
      else $error("query reported a class change");

endmodule

bind log_odds_occupancy_grid logg_checker u_logg_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);
